// ===== src/ywr_pkg.sv =====
// ----------------------------------------------------------------------------
// ywr_pkg
// Types and constants shared by the yaw-rate steering estimator.
// ----------------------------------------------------------------------------
package ywr_pkg;

  typedef struct packed {
    logic [5:0]         vehicle_slot;
    logic               clear_slot;
    logic               eligible;
    logic signed [15:0] forward_x;
    logic signed [15:0] forward_y;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic signed [15:0] speed_z;
    logic [15:0]        time_step;
  } ywr_in_t;

  typedef struct packed {
    logic signed [14:0] wheel_angle_deg;
    logic               rotate_wheels;
  } ywr_out_t;

  localparam int CORDIC_W = 52;
  localparam int ANGLE_W  = 36;
  localparam int DIV_W    = 40;
  localparam int TABLE_LEN = 24;

  typedef struct packed {
    logic                       start;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
  } ywr_cordic_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [ANGLE_W-1:0] z;
  } ywr_cordic_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [4:0]       divisor;
  } ywr_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } ywr_div_rsp_t;

  localparam logic [1:0] CFG_WHEELBASE_GAIN = 2'd0;
  localparam logic [1:0] CFG_MIN_SPEED      = 2'd1;
  localparam logic [1:0] CFG_MAX_STEER      = 2'd2;
  localparam logic [1:0] CFG_SMOOTHING_RATE = 2'd3;

  localparam logic [11:0] GAIN_RESET      = 12'd666;
  localparam logic [11:0] MIN_SPEED_RESET = 12'd102;
  localparam logic [13:0] MAX_STEER_RESET = 14'd4915;
  localparam logic [11:0] RATE_RESET      = 12'd1280;

  localparam logic [15:0]        TS_MIN           = 16'd205;
  localparam logic [15:0]        TS_MAX           = 16'd10240;
  localparam logic [13:0]        STEER_LIMIT      = 14'd12868;
  localparam logic signed [19:0] TWO_PI_Q16       = 20'sd411775;
  localparam logic [31:0]        TWO_PI_Q29       = 32'd3373259426;
  localparam logic [15:0]        RAD_TO_DEG       = 16'd58671;
  localparam logic [29:0]        ROTATE_THRESHOLD = 30'd83887;
  localparam logic [13:0]        DEG_LIMIT        = 14'd11520;
  localparam logic [11:0]        SPEED_SCALE      = 12'd2500;
  localparam logic [4:0]         U_DIVISOR        = 5'd25;
  localparam logic [4:0]         EXP_TERMS        = 5'd16;

  localparam logic [29:0] ATAN_TURN [TABLE_LEN] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

endpackage

// ===== src/ywr_stream_if.sv =====
// ----------------------------------------------------------------------------
// ywr_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface ywr_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ===== src/ywr_cordic.sv =====
// ----------------------------------------------------------------------------
// ywr_cordic
// Iterative vectoring CORDIC, atan2 in 2^-32 turn, one step per cycle.
// ----------------------------------------------------------------------------
module ywr_cordic
  import ywr_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  ywr_cordic_req_t req,
  output ywr_cordic_rsp_t rsp
);

  localparam int N = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  logic signed [CORDIC_W-1:0] x, y, xs, ys;
  logic signed [ANGLE_W-1:0]  z, za;
  logic [4:0] i;
  logic busy, done;

  assign xs = x >>> i;
  assign ys = y >>> i;
  assign za = $signed({6'b0, ATAN_TURN[i]});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        i    <= '0;
        busy <= 1'b1;
        if (req.x < 0) begin
          if (req.y >= 0) begin
            x <= req.y;
            y <= -req.x;
            z <= 36'sd1073741824;
          end else begin
            x <= -req.y;
            y <= req.x;
            z <= -36'sd1073741824;
          end
        end else begin
          x <= req.x;
          y <= req.y;
          z <= '0;
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + za;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - za;
        end
        i <= i + 5'd1;
        if (i == 5'(N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, z: z};

endmodule

// ===== src/ywr_divider.sv =====
// ----------------------------------------------------------------------------
// ywr_divider
// Restoring divider by a small divisor, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module ywr_divider
  import ywr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  ywr_div_req_t req,
  output ywr_div_rsp_t rsp
);

  localparam int STEPS = DIV_W / 4;

  logic [DIV_W-1:0] dvd, quo;
  logic [4:0] dsr, rem, rem_next;
  logic [3:0] qbits;
  logic [3:0] cnt;
  logic busy, done;

  always_comb begin
    logic [5:0] r;
    logic [4:0] acc;
    acc = rem;
    for (int j = 0; j < 4; j++) begin
      r = {acc, dvd[DIV_W-1-j]};
      if (r >= {1'b0, dsr}) begin
        r = r - {1'b0, dsr};
        qbits[3-j] = 1'b1;
      end else begin
        qbits[3-j] = 1'b0;
      end
      acc = r[4:0];
    end
    rem_next = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        dvd <= dvd << 4;
        quo <= {quo[DIV_W-5:0], qbits};
        rem <= rem_next;
        cnt <= cnt + 4'd1;
        if (cnt == 4'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quotient: quo};

endmodule

// ===== src/yaw_rate_steering_estimator.sv =====
// ----------------------------------------------------------------------------
// yaw_rate_steering_estimator
// Per-slot steering angle estimate from heading change, speed and time step.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   handshake
//  items     in   slot, clear, eligible, forward, speed, dt  valid/ready
//  results   out  wheel_angle_deg, rotate_wheels             valid/ready
//  cfg       in   cfg_index, cfg_data                        cfg_we
//
//  Requests are handled one at a time; the 16-term exp series takes most
//  of a full update.
//  A first request for a slot only stores its heading and returns zero.
//  Cleared, ineligible or out-of-range requests go straight to the result.
//  A result waits in the output register; the next request is taken meanwhile.
//  After reset a pass over every slot clears the slot memory;
//  requests wait until it ends.
// ----------------------------------------------------------------------------
module yaw_rate_steering_estimator
  import ywr_pkg::*;
#(
  parameter int VEHICLE_SLOTS = 64,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  ywr_stream_if.sink   items,
  ywr_stream_if.source results,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int AW = (VEHICLE_SLOTS > 1) ? $clog2(VEHICLE_SLOTS) : 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HEAD_START, S_HEAD_WAIT, S_SQUARE, S_SUM, S_TEST, S_SQRT,
    S_XMUL, S_ANG_START, S_ANG_WAIT, S_TMUL, S_TRND, S_U_WAIT, S_EXP_MUL,
    S_EXP_DIV, S_EXP_WAIT, S_BLEND, S_STEP_MUL, S_STEP, S_DEG_MUL, S_DEG,
    S_RESULT
  } state_t;

  state_t state;

  logic [11:0] wheelbase_gain, min_speed, smoothing_rate;
  logic [13:0] max_steer;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheelbase_gain <= GAIN_RESET;
      min_speed      <= MIN_SPEED_RESET;
      max_steer      <= MAX_STEER_RESET;
      smoothing_rate <= RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHEELBASE_GAIN: wheelbase_gain <= cfg_data[11:0];
        CFG_MIN_SPEED:      min_speed      <= cfg_data[11:0];
        CFG_MAX_STEER:      max_steer      <= cfg_data;
        CFG_SMOOTHING_RATE: smoothing_rate <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // slot memory: {valid, prev_heading, smoothed_steer}
  logic [32:0] mem [VEHICLE_SLOTS];
  logic [32:0] mem_rdata, mem_wdata;
  logic [AW-1:0] mem_waddr, in_addr;
  logic mem_we;
  logic [AW:0] clr_addr;

  ywr_in_t item;
  logic [AW-1:0] addr;
  logic [15:0] in_slot_w;
  logic in_range, item_acc;

  assign in_slot_w = 16'(items.payload.vehicle_slot);
  assign in_addr   = in_slot_w[AW-1:0];
  assign in_range  = in_slot_w < 16'(VEHICLE_SLOTS);
  assign item_acc  = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (item_acc) mem_rdata <= mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  ywr_cordic_req_t cordic_req;
  ywr_cordic_rsp_t cordic_rsp;
  ywr_div_req_t    div_req;
  ywr_div_rsp_t    div_rsp;

  ywr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .req(cordic_req), .rsp(cordic_rsp)
  );

  ywr_divider u_divider (
    .clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp)
  );

  logic [15:0] prev_head, head_new;
  logic signed [15:0] steer, dlt, s_new;
  logic was_valid, fast;
  logic [30:0] sqx, sqy, sqz, xprod;
  logic signed [28:0] gd;
  logic [23:0] min2;
  logic [25:0] rt;
  logic [31:0] mag2, sq_v, sq_r, sq_bit, a_mag, u;
  logic signed [48:0] yv;
  logic [4:0] cnt, k;
  logic a_neg;
  logic [63:0] tprod;
  logic signed [16:0] target;
  logic [32:0] term;
  logic signed [35:0] sum;
  logic [64:0] eprod;
  logic [16:0] blend;
  logic signed [17:0] diff;
  logic [33:0] dprod;
  logic [29:0] pdeg;
  logic out_valid;
  ywr_out_t out_data;
  ywr_out_t results_data_q;

  // combinational helpers
  logic [13:0] ts_c, lim, s_abs, deg_mag;
  logic signed [35:0] hz;
  logic [15:0] head_w, tmag;
  logic [63:0] tr;
  logic signed [16:0] t_raw, lim_s, t_clamp;
  logic signed [31:0] sqx_w, sqy_w, sqz_w;
  logic signed [28:0] gd_w;
  logic signed [48:0] yv_w;
  logic [43:0] speed_lhs, speed_rhs;
  logic [32:0] rb;
  logic [32:0] sumc;
  logic [33:0] blend_w;
  logic [16:0] diff_abs;
  logic [33:0] ds;
  logic [17:0] step_mag;
  logic signed [18:0] s_sum;
  logic signed [15:0] s_clamp;
  logic [30:0] pr;
  logic [14:0] deg_r;
  logic [13:0] deg_c;
  logic signed [14:0] deg_w;
  logic [32:0] term_q;
  logic signed [35:0] term_s;

  always_comb begin
    if (item.time_step < TS_MIN) ts_c = TS_MIN[13:0];
    else if (item.time_step > TS_MAX) ts_c = TS_MAX[13:0];
    else ts_c = item.time_step[13:0];
    lim = (max_steer > STEER_LIMIT) ? STEER_LIMIT : max_steer;
  end

  assign hz     = cordic_rsp.z + 36'sd32768;
  assign head_w = hz[31:16];

  assign sqx_w = item.speed_x * item.speed_x;
  assign sqy_w = item.speed_y * item.speed_y;
  assign sqz_w = item.speed_z * item.speed_z;
  assign gd_w  = $signed({1'b0, wheelbase_gain}) * dlt;
  assign yv_w  = gd * TWO_PI_Q16;

  assign speed_lhs = 44'(mag2) * 44'(SPEED_SCALE);
  assign speed_rhs = 44'({min2, 8'b0});

  assign rb = {1'b0, sq_r} + {1'b0, sq_bit};

  assign tr      = tprod + (64'd1 << 47);
  assign tmag    = tr[63:48];
  assign t_raw   = a_neg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
  assign lim_s   = $signed({3'b0, lim});
  always_comb begin
    if (!fast) t_clamp = '0;
    else if (t_raw > lim_s) t_clamp = lim_s;
    else if (t_raw < -lim_s) t_clamp = -lim_s;
    else t_clamp = t_raw;
  end

  assign term_q = div_rsp.quotient[32:0];
  assign term_s = $signed({3'b0, term_q});

  always_comb begin
    if (sum < 0) sumc = '0;
    else if (sum > 36'sd4294967296) sumc = 33'h1_0000_0000;
    else sumc = sum[32:0];
  end
  assign blend_w = (34'd1 << 32) - {1'b0, sumc} + 34'd32768;

  assign diff_abs = diff[17] ? 17'(-diff) : diff[16:0];
  assign ds       = dprod + 34'd32768;
  assign step_mag = ds[33:16];
  assign s_sum    = diff[17] ? (19'(steer) - $signed({1'b0, step_mag}))
                             : (19'(steer) + $signed({1'b0, step_mag}));
  always_comb begin
    if (s_sum > $signed({5'b0, STEER_LIMIT})) s_clamp = $signed({2'b0, STEER_LIMIT});
    else if (s_sum < -$signed({5'b0, STEER_LIMIT})) s_clamp = -$signed({2'b0, STEER_LIMIT});
    else s_clamp = s_sum[15:0];
  end

  assign s_abs   = s_new[15] ? 14'(-s_new) : s_new[13:0];
  assign pr      = {1'b0, pdeg} + 31'd32768;
  assign deg_r   = pr[30:16];
  assign deg_c   = (deg_r > 15'(DEG_LIMIT)) ? DEG_LIMIT : deg_r[13:0];
  assign deg_w   = s_new[15] ? -$signed({1'b0, deg_c}) : $signed({1'b0, deg_c});

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      mem_we     <= 1'b0;
      cordic_req <= '0;
      div_req    <= '0;
    end else begin
      mem_we           <= 1'b0;
      cordic_req.start <= 1'b0;
      div_req.start    <= 1'b0;
      if (results.ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == (AW+1)'(VEHICLE_SLOTS)) begin
            state <= S_IDLE;
          end else begin
            mem_we    <= 1'b1;
            mem_waddr <= clr_addr[AW-1:0];
            mem_wdata <= '0;
            clr_addr  <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (item_acc) begin
            item <= items.payload;
            addr <= in_addr;
            if (!in_range || items.payload.clear_slot || !items.payload.eligible) begin
              if (in_range && items.payload.clear_slot) begin
                mem_we    <= 1'b1;
                mem_waddr <= in_addr;
                mem_wdata <= '0;
              end
              s_new <= '0;
              pdeg  <= '0;
              state <= S_DEG;
            end else begin
              state <= S_HEAD_START;
            end
          end
        end
        S_HEAD_START: begin
          prev_head  <= mem_rdata[31:16];
          steer      <= mem_rdata[15:0];
          was_valid  <= mem_rdata[32];
          cordic_req <= '{start: 1'b1,
                          x: {{20{item.forward_x[15]}}, item.forward_x, 16'b0},
                          y: {{20{item.forward_y[15]}}, item.forward_y, 16'b0}};
          state <= S_HEAD_WAIT;
        end
        S_HEAD_WAIT: begin
          if (cordic_rsp.done) begin
            head_new <= head_w;
            if (!was_valid) begin
              mem_we           <= 1'b1;
              mem_waddr        <= addr;
              mem_wdata        <= {1'b1, head_w, 16'd0};
              s_new            <= '0;
              pdeg             <= '0;
              state            <= S_DEG;
            end else begin
              dlt   <= head_w - prev_head;
              state <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          sqx   <= sqx_w[30:0];
          sqy   <= sqy_w[30:0];
          sqz   <= sqz_w[30:0];
          gd    <= gd_w;
          min2  <= min_speed * min_speed;
          rt    <= smoothing_rate * ts_c;
          state <= S_SUM;
        end
        S_SUM: begin
          mag2  <= 32'(sqx) + 32'(sqy) + 32'(sqz);
          yv    <= yv_w;
          state <= S_TEST;
        end
        S_TEST: begin
          fast   <= speed_lhs > speed_rhs;
          sq_v   <= mag2;
          sq_r   <= '0;
          sq_bit <= 32'h4000_0000;
          cnt    <= '0;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          if ({1'b0, sq_v} >= rb) begin
            sq_v <= sq_v - rb[31:0];
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 5'd1;
          if (cnt == 5'd15) state <= S_XMUL;
        end
        S_XMUL: begin
          xprod <= sq_r[16:0] * ts_c;
          state <= S_ANG_START;
        end
        S_ANG_START: begin
          cordic_req <= '{start: 1'b1,
                          x: {5'b0, xprod, 16'b0},
                          y: {{3{yv[48]}}, yv}};
          state <= S_ANG_WAIT;
        end
        S_ANG_WAIT: begin
          if (cordic_rsp.done) begin
            a_neg <= cordic_rsp.z < 0;
            a_mag <= (cordic_rsp.z < 0) ? 32'(-cordic_rsp.z) : cordic_rsp.z[31:0];
            state <= S_TMUL;
          end
        end
        S_TMUL: begin
          tprod <= a_mag * TWO_PI_Q29;
          state <= S_TRND;
        end
        S_TRND: begin
          target  <= t_clamp;
          div_req <= '{start: 1'b1, dividend: 40'({rt, 11'b0}) + 40'd12,
                       divisor: U_DIVISOR};
          state   <= S_U_WAIT;
        end
        S_U_WAIT: begin
          if (div_rsp.done) begin
            u     <= div_rsp.quotient[31:0];
            term  <= 33'h1_0000_0000;
            sum   <= 36'sd4294967296;
            k     <= 5'd1;
            state <= S_EXP_MUL;
          end
        end
        S_EXP_MUL: begin
          eprod <= 65'(term) * 65'(u);
          state <= S_EXP_DIV;
        end
        S_EXP_DIV: begin
          div_req <= '{start: 1'b1, dividend: 40'(eprod[63:32]), divisor: k};
          state   <= S_EXP_WAIT;
        end
        S_EXP_WAIT: begin
          if (div_rsp.done) begin
            term <= term_q;
            sum  <= k[0] ? (sum - term_s) : (sum + term_s);
            k    <= k + 5'd1;
            state <= (k == EXP_TERMS) ? S_BLEND : S_EXP_MUL;
          end
        end
        S_BLEND: begin
          blend <= blend_w[32:16];
          diff  <= 18'(target) - 18'(steer);
          state <= S_STEP_MUL;
        end
        S_STEP_MUL: begin
          dprod <= diff_abs * blend;
          state <= S_STEP;
        end
        S_STEP: begin
          s_new     <= s_clamp;
          mem_we    <= 1'b1;
          mem_waddr <= addr;
          mem_wdata <= {1'b1, head_new, s_clamp};
          state     <= S_DEG_MUL;
        end
        S_DEG_MUL: begin
          pdeg  <= s_abs * RAD_TO_DEG;
          state <= S_DEG;
        end
        S_DEG: begin
          out_data.wheel_angle_deg <= deg_w;
          out_data.rotate_wheels   <= pdeg >= ROTATE_THRESHOLD;
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || results.ready) begin
            out_valid        <= 1'b1;
            results_data_q   <= out_data;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign items.ready     = (state == S_IDLE);
  assign results.valid   = out_valid;
  assign results.payload = results_data_q;

endmodule

// ===== src/ywr_checker.sv =====
// ----------------------------------------------------------------------------
// ywr_checker
// Port-level checks for the yaw-rate steering estimator.
// ----------------------------------------------------------------------------
module ywr_checker
  import ywr_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     items_valid,
  input logic     items_ready,
  input logic     results_valid,
  input logic     results_ready,
  input ywr_out_t results_payload
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=> results_valid)
    else $error("result dropped while stalled");

  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=> $stable(results_payload))
    else $error("result changed while stalled");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    items_valid && items_ready |=> !items_ready)
    else $error("second request taken while busy");

  a_rotate_nonzero: assert property (@(posedge clk) disable iff (rst)
    results_valid && results_payload.rotate_wheels |->
      results_payload.wheel_angle_deg != 15'sd0)
    else $error("rotate flag with zero angle");

endmodule

bind yaw_rate_steering_estimator ywr_checker u_ywr_checker (
  .clk(clk),
  .rst(rst),
  .items_valid(items.valid),
  .items_ready(items.ready),
  .results_valid(results.valid),
  .results_ready(results.ready),
  .results_payload(results.payload)
);
